[rtl/core/interval_set_merge_and_gaps_defines.svh]
// ----------------------------------------------------------------------------
// Interval set assertion macros
// Shared property forms for the interval set block.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_SET_MERGE_AND_GAPS_DEFINES_SVH
`define INTERVAL_SET_MERGE_AND_GAPS_DEFINES_SVH

// Same-cycle implication, ignored while in reset.
`define ISM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("interval set check failed");

// Next-cycle implication, ignored while in reset.
`define ISM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("interval set check failed");

`endif

[rtl/core/ism_pkg.sv]
// ----------------------------------------------------------------------------
// ism_pkg
// Types, codes and helpers shared by the interval set block.
// ----------------------------------------------------------------------------
`default_nettype none
package ism_pkg;

  localparam int DEF_MAX_RANGES = 32;
  localparam int COUNT_W        = 6;
  localparam int DATA_W         = 64;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_QUERY = 2'd1,
    FUNC_GAPS  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_FETCH,
    ST_PROC,
    ST_INSERT,
    ST_FINISH,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic step;
    logic insert;
    logic fin;
    logic result;
  } cmd_t;

  typedef struct packed {
    logic single;
    logic empty;
    logic split;
    logic last;
    logic push_step;
    logic push_fin;
    logic room;
  } sts_t;

  // End of a range, saturated at the top of the address space.
  function automatic logic [DATA_W-1:0] sat_end(input logic [DATA_W-1:0] off,
                                                input logic [DATA_W-1:0] len);
    logic [DATA_W:0] sum;
    sum = {1'b0, off} + {1'b0, len};
    return sum[DATA_W] ? {DATA_W{1'b1}} : sum[DATA_W-1:0];
  endfunction

endpackage
`default_nettype wire

[rtl/core/ism_ram.sv]
// ----------------------------------------------------------------------------
// ism_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ism_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/core/ism_ctrl.sv]
// ----------------------------------------------------------------------------
// ism_ctrl
// Sequencer: walks the table at most once per item and orders the datapath steps.
// ----------------------------------------------------------------------------
`default_nettype none
module ism_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire ism_pkg::sts_t sts,
  output ism_pkg::cmd_t      cmd
);
  import ism_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        if (sts.single)     state_next = ST_RESULT;
        else if (sts.empty) state_next = ST_FINISH;
        else                state_next = ST_FETCH;
      end
      ST_FETCH:    state_next = ST_PROC;
      ST_PROC: begin
        if (!(sts.push_step && !sts.room)) begin
          if (sts.split)     state_next = ST_INSERT;
          else if (sts.last) state_next = ST_FINISH;
          else               state_next = ST_FETCH;
        end
      end
      ST_INSERT:   state_next = sts.last ? ST_FINISH : ST_FETCH;
      ST_FINISH:   if (!(sts.push_fin && !sts.room)) state_next = ST_RESULT;
      ST_RESULT:   if (sts.room) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE:     cmd.load   = in_valid;
      ST_DISPATCH: ;
      ST_FETCH:    cmd.rd     = 1'b1;
      ST_PROC:     cmd.step   = !(sts.push_step && !sts.room);
      ST_INSERT:   cmd.insert = 1'b1;
      ST_FINISH:   cmd.fin    = !(sts.push_fin && !sts.room);
      ST_RESULT:   cmd.result = sts.room;
      default:     ;
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/ism_dp.sv]
// ----------------------------------------------------------------------------
// ism_dp
// Datapath: ping-pong range tables, merge, overlap and gap logic, result reg.
// ----------------------------------------------------------------------------
`default_nettype none
module ism_dp #(
  parameter int MAX_RANGES = ism_pkg::DEF_MAX_RANGES
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire ism_pkg::cmd_t                  cmd,
  output ism_pkg::sts_t                       sts,
  input  wire logic [1:0]                     func,
  input  wire logic [ism_pkg::DATA_W-1:0]     region_offset,
  input  wire logic [ism_pkg::DATA_W-1:0]     region_length,
  input  wire logic [ism_pkg::DATA_W-1:0]     device_size,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                overlap_hit,
  output logic                                gap_valid,
  output logic      [ism_pkg::DATA_W-1:0]     gap_offset,
  output logic      [ism_pkg::DATA_W-1:0]     gap_length,
  output logic                                last_result,
  output logic      [ism_pkg::DATA_W-1:0]     claimed_total,
  output logic      [ism_pkg::COUNT_W-1:0]    entry_count,
  output logic                                table_full
);
  import ism_pkg::*;

  localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam int EW = 2 * DATA_W;

  func_t             op;
  logic [DATA_W-1:0] off, len, dev, fend, ns, nf, cur, pg_off, pg_len, wsum, total;
  logic              inserted, absorbed, hit, pg_have, bank, drop;
  logic [CW-1:0]     idx, widx, count;

  logic [EW-1:0]     rdata0, rdata1, ent, wr_data;
  logic [DATA_W-1:0] a, b, up, lim, wdiff, wsum_add;
  logic              is_add, is_query, is_gaps, below, split, gap, fgap;
  logic              wr_en, drop_now, adv, push_gap, room;
  logic [CW-1:0]     widx_add;

  assign ent      = bank ? rdata1 : rdata0;
  assign a        = ent[EW-1:DATA_W];
  assign b        = ent[DATA_W-1:0];
  assign is_add   = (op == FUNC_ADD);
  assign is_query = (op == FUNC_QUERY);
  assign is_gaps  = (op == FUNC_GAPS);
  assign below    = b < ns;
  assign split    = is_add && !inserted && (a > nf);
  assign up       = (a < dev) ? a : dev;
  assign lim      = (b < dev) ? b : dev;
  assign gap      = up > cur;
  assign fgap     = dev > cur;
  assign drop_now = !absorbed && (count == CW'(MAX_RANGES));
  assign room     = !out_valid || !out_stall;

  // Write port of the shadow bank: copy, insert ahead, or final append.
  always_comb begin
    wr_en   = 1'b0;
    wr_data = ent;
    if (cmd.step && is_add) begin
      wr_en   = inserted || below || split;
      wr_data = split ? {ns, nf} : ent;
    end else if (cmd.insert) begin
      wr_en = 1'b1;
    end else if (cmd.fin && is_add) begin
      wr_en   = !inserted && !drop_now;
      wr_data = {ns, nf};
    end
  end

  assign wdiff    = wr_data[DATA_W-1:0] - wr_data[EW-1:DATA_W];
  assign wsum_add = wsum + (wr_en ? wdiff : '0);
  assign widx_add = widx + CW'(wr_en);
  assign adv      = (cmd.step && !split) || cmd.insert;
  assign push_gap = (cmd.step && sts.push_step) || (cmd.fin && sts.push_fin);

  always_comb begin
    sts           = '0;
    sts.single    = (op == FUNC_NONE) || ((is_add || is_query) && (len == '0));
    sts.empty     = (count == '0);
    sts.split     = split;
    sts.last      = ({1'b0, idx} + 1'b1) == {1'b0, count};
    sts.push_step = is_gaps && gap && pg_have;
    sts.push_fin  = is_gaps && fgap && pg_have;
    sts.room      = room;
  end

  ism_ram #(.WIDTH(EW), .DEPTH(MAX_RANGES)) u_bank0 (
    .clk(clk), .we(wr_en && bank), .waddr(widx[AW-1:0]), .wdata(wr_data),
    .re(cmd.rd), .raddr(idx[AW-1:0]), .rdata(rdata0)
  );

  ism_ram #(.WIDTH(EW), .DEPTH(MAX_RANGES)) u_bank1 (
    .clk(clk), .we(wr_en && !bank), .waddr(widx[AW-1:0]), .wdata(wr_data),
    .re(cmd.rd), .raddr(idx[AW-1:0]), .rdata(rdata1)
  );

  // Table control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      bank     <= 1'b0;
      count    <= '0;
      total    <= '0;
      inserted <= 1'b0;
      absorbed <= 1'b0;
      pg_have  <= 1'b0;
      drop     <= 1'b0;
      idx      <= '0;
      widx     <= '0;
    end else if (cmd.load) begin
      inserted <= 1'b0;
      absorbed <= 1'b0;
      pg_have  <= 1'b0;
      drop     <= 1'b0;
      idx      <= '0;
      widx     <= '0;
    end else begin
      if (adv) idx <= idx + 1'b1;
      widx <= widx_add;
      if (cmd.step && is_add) begin
        if (split) inserted <= 1'b1;
        else if (!inserted && !below) absorbed <= 1'b1;
      end
      if (cmd.fin && is_add) begin
        drop <= drop_now;
        if (!drop_now) begin
          bank  <= ~bank;
          count <= widx_add;
          total <= wsum_add;
        end
      end
      if ((cmd.step && gap && is_gaps) || (cmd.fin && fgap && is_gaps)) pg_have <= 1'b1;
    end
  end

  // Operand and walk registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= func_t'(func);
      off  <= region_offset;
      len  <= region_length;
      dev  <= device_size;
      fend <= sat_end(region_offset, region_length);
      ns   <= region_offset;
      nf   <= sat_end(region_offset, region_length);
      hit  <= 1'b0;
      cur  <= '0;
      wsum <= '0;
    end else begin
      wsum <= wsum_add;
      if (cmd.step) begin
        unique case (op)
          FUNC_ADD: begin
            if (!inserted && !below && !split) begin
              if (a < ns) ns <= a;
              if (b > nf) nf <= b;
            end
          end
          FUNC_QUERY: if ((a < fend) && (b > off)) hit <= 1'b1;
          FUNC_GAPS: begin
            if (gap) begin
              pg_off <= cur;
              pg_len <= up - cur;
            end
            if (lim > cur) cur <= lim;
          end
          default: ;
        endcase
      end
      if (cmd.fin && is_gaps && fgap) begin
        pg_off <= cur;
        pg_len <= dev - cur;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= push_gap || cmd.result || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (push_gap || cmd.result) begin
      overlap_hit   <= cmd.result && is_query && hit;
      gap_valid     <= push_gap || (is_gaps && pg_have);
      gap_offset    <= (push_gap || (is_gaps && pg_have)) ? pg_off : '0;
      gap_length    <= (push_gap || (is_gaps && pg_have)) ? pg_len : '0;
      last_result   <= cmd.result;
      claimed_total <= total;
      entry_count   <= COUNT_W'(count);
      table_full    <= cmd.result && is_add && drop;
    end
  end

endmodule
`default_nettype wire

[rtl/core/interval_set_merge_and_gaps.sv]
// ----------------------------------------------------------------------------
// interval_set_merge_and_gaps
// Sorted table of disjoint byte ranges with add/merge, overlap query and gaps.
// ----------------------------------------------------------------------------
// One item is handled at a time. An item that walks the stored ranges passes,
// from acceptance until the input opens again, through accept, dispatch, a
// read state and a process state per stored range (one read port, registered
// read), finish and result. An add that places its new range ahead of a
// stored one spends an extra insert state on that write, and the item waits
// while a due result finds the result register stalled. Zero-length adds and
// queries and unknown commands skip the walk and go from dispatch to result;
// other items on an empty table pass through finish only. An add streams the
// table into a second bank, fusing touching ranges on the way, and swaps
// banks at the end unless the table was full. Gaps results are held one
// behind so the last one can be marked; each further gap waits only if the
// result register is still stalled.
`default_nettype none
`include "interval_set_merge_and_gaps_defines.svh"
module interval_set_merge_and_gaps #(
  parameter int MAX_RANGES = ism_pkg::DEF_MAX_RANGES
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  func,
  input  wire logic [ism_pkg::DATA_W-1:0]  region_offset,
  input  wire logic [ism_pkg::DATA_W-1:0]  region_length,
  input  wire logic [ism_pkg::DATA_W-1:0]  device_size,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             overlap_hit,
  output logic                             gap_valid,
  output logic      [ism_pkg::DATA_W-1:0]  gap_offset,
  output logic      [ism_pkg::DATA_W-1:0]  gap_length,
  output logic                             last_result,
  output logic      [ism_pkg::DATA_W-1:0]  claimed_total,
  output logic      [ism_pkg::COUNT_W-1:0] entry_count,
  output logic                             table_full
);
  import ism_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer: one state per walk step.
  ism_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .cmd(cmd)
  );

  // Tables, per-entry logic and the result register.
  ism_dp #(.MAX_RANGES(MAX_RANGES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .func(func), .region_offset(region_offset), .region_length(region_length),
    .device_size(device_size),
    .out_valid(out_valid), .out_stall(out_stall),
    .overlap_hit(overlap_hit), .gap_valid(gap_valid), .gap_offset(gap_offset),
    .gap_length(gap_length), .last_result(last_result),
    .claimed_total(claimed_total), .entry_count(entry_count),
    .table_full(table_full)
  );

  // Only one datapath command per cycle.
  `ISM_ASSERT_IMP(a_cmd_onehot, 1'b1, $onehot0(cmd))
  // An accepted item closes the input until it is done.
  `ISM_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // An emitted gap is never empty and never comes with a full flag.
  `ISM_ASSERT_IMP(a_gap_nonempty, out_valid && gap_valid, gap_length != '0 && !table_full)
  // A dropped add is a single final result.
  `ISM_ASSERT_IMP(a_full_last, out_valid && table_full, last_result && !overlap_hit)

endmodule
`default_nettype wire

[bench/interval_set_merge_and_gaps_test.sv]
// ----------------------------------------------------------------------------
// interval_set_merge_and_gaps_test
// Drives add, overlap, gaps and unknown items into the interval set, predicts
// every result with a behavioral copy of the range table, compares each field.
// ----------------------------------------------------------------------------
`default_nettype none
module interval_set_merge_and_gaps_test;
  import ism_pkg::*;

  localparam int NRANGE = DEF_MAX_RANGES;
  localparam logic [63:0] TOP = 64'hFFFF_FFFF_FFFF_FFFF;

  // One expected result item.
  typedef struct packed {
    logic        hit;
    logic        gv;
    logic [63:0] goff;
    logic [63:0] glen;
    logic        last;
    logic [63:0] total;
    logic [5:0]  count;
    logic        full;
  } result_t;

  // One stimulus row; chk set means the typed-in answer is compared too.
  typedef struct {
    func_t       f;
    logic [63:0] off;
    logic [63:0] len;
    logic [63:0] dev;
    bit          chk;
    result_t     res;
  } row_t;

  logic        clk, rst;
  logic        in_valid, in_stall;
  logic [1:0]  func;
  logic [63:0] region_offset, region_length, device_size;
  logic        out_valid, out_stall;
  logic        overlap_hit, gap_valid, last_result, table_full;
  logic [63:0] gap_offset, gap_length, claimed_total;
  logic [5:0]  entry_count;

  interval_set_merge_and_gaps uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .region_offset(region_offset),
    .region_length(region_length), .device_size(device_size),
    .out_valid(out_valid), .out_stall(out_stall),
    .overlap_hit(overlap_hit), .gap_valid(gap_valid),
    .gap_offset(gap_offset), .gap_length(gap_length),
    .last_result(last_result), .claimed_total(claimed_total),
    .entry_count(entry_count), .table_full(table_full)
  );

  // Predictor copy of the range table.
  logic [63:0] span_lo [NRANGE];
  logic [63:0] span_hi [NRANGE];
  int          span_cnt;
  logic [63:0] span_bytes;

  result_t expected_results[$];
  int      fails;
  int      mismatches;

  // Idle mode: 0 none, 1 sender, 2 receiver, 3 both.
  int idle_mode;
  int hold_cycles;

  function automatic logic [63:0] clip_end(logic [63:0] o, logic [63:0] l);
    return (l > TOP - o) ? TOP : o + l;
  endfunction

  function automatic int first_above(logic [63:0] key);
    int i;
    i = 0;
    while (i < span_cnt && span_lo[i] <= key) i++;
    return i;
  endfunction

  function automatic result_t make_res(logic h, logic gv, logic [63:0] go,
                                       logic [63:0] gl, logic l, logic fu);
    result_t r;
    r.hit = h; r.gv = gv; r.goff = go; r.glen = gl; r.last = l;
    r.total = span_bytes; r.count = span_cnt[5:0]; r.full = fu;
    return r;
  endfunction

  // Returns 1 when the range did not fit.
  function automatic bit merge_range(logic [63:0] o, logic [63:0] l);
    logic [63:0] s, e, sum;
    int p, i, j, n, k, gone;
    if (l == 0) return 0;
    s = o;
    e = clip_end(o, l);
    n = span_cnt;
    p = first_above(s);
    i = (p > 0 && span_hi[p-1] >= s) ? p - 1 : p;
    j = i;
    while (j < n && span_lo[j] <= e) begin
      if (span_lo[j] < s) s = span_lo[j];
      if (span_hi[j] > e) e = span_hi[j];
      j++;
    end
    gone = j - i;
    if (gone == 0 && n >= NRANGE) return 1;
    if (gone == 0) begin
      for (k = n; k > i; k--) begin
        span_lo[k] = span_lo[k-1];
        span_hi[k] = span_hi[k-1];
      end
      n++;
    end else begin
      for (k = 0; j + k < n; k++) begin
        span_lo[i+1+k] = span_lo[j+k];
        span_hi[i+1+k] = span_hi[j+k];
      end
      n = n - gone + 1;
    end
    span_lo[i] = s;
    span_hi[i] = e;
    span_cnt = n;
    sum = 0;
    for (k = 0; k < n; k++) sum += span_hi[k] - span_lo[k];
    span_bytes = sum;
    return 0;
  endfunction

  function automatic bit shares_byte(logic [63:0] o, logic [63:0] l);
    int p;
    if (l == 0) return 0;
    p = first_above(o);
    if (p > 0 && span_hi[p-1] > o) return 1;
    return p < span_cnt && span_lo[p] < clip_end(o, l);
  endfunction

  // Append one expectation to the tail of the queue.
  task automatic queue_result(result_t r);
    expected_results = {expected_results, r};
  endtask

  // Work out the results of one accepted item and queue them.
  task automatic predict_table_op(logic [1:0] f, logic [63:0] o,
                                  logic [63:0] l, logic [63:0] d);
    logic [63:0] cur, up, lim;
    result_t gaps[$];
    bit fu;
    case (f)
      FUNC_ADD: begin
        fu = merge_range(o, l);
        queue_result(make_res(0, 0, 0, 0, 1, fu));
      end
      FUNC_QUERY: begin
        queue_result(make_res(shares_byte(o, l), 0, 0, 0, 1, 0));
      end
      FUNC_GAPS: begin
        cur = 0;
        for (int i = 0; i < span_cnt; i++) begin
          up = span_lo[i] < d ? span_lo[i] : d;
          if (up > cur) begin
            gaps = {gaps, make_res(0, 1, cur, up - cur, 0, 0)};
            cur = up;
          end
          lim = span_hi[i] < d ? span_hi[i] : d;
          if (lim > cur) cur = lim;
        end
        if (d > cur) gaps = {gaps, make_res(0, 1, cur, d - cur, 0, 0)};
        if (gaps.size() == 0) gaps = {gaps, make_res(0, 0, 0, 0, 1, 0)};
        else gaps[gaps.size()-1].last = 1'b1;
        foreach (gaps[k]) queue_result(gaps[k]);
      end
      default: queue_result(make_res(0, 0, 0, 0, 1, 0));
    endcase
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{overlap_hit, gap_valid, gap_offset, gap_length, last_result,
              claimed_total, entry_count, table_full};
      if (expected_results.size() == 0) begin
        fails++;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item: %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          fails++;
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // Receiver: stall at random per mode, or hold off for a long stretch.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (idle_mode >= 2) begin
      out_stall <= ($urandom_range(99) < (idle_mode == 3 ? 20 : 53));
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one item and wait until it is accepted; valid stays up for the
  // next item unless the sender idles first.
  task automatic send_item(logic [1:0] f, logic [63:0] o, logic [63:0] l,
                           logic [63:0] d);
    int pct;
    pct = idle_mode == 1 ? 53 : (idle_mode == 3 ? 20 : 0);
    while ($urandom_range(99) < pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    region_offset <= o;
    region_length <= l;
    device_size <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_table_op(f, o, l, d);
  endtask

  // Random byte address: mostly in a small window so ranges collide.
  function automatic logic [63:0] rand_addr();
    case ($urandom_range(9))
      0:       return {$urandom, $urandom};
      1:       return TOP - $urandom_range(300);
      default: return $urandom_range(4000);
    endcase
  endfunction

  function automatic logic [63:0] rand_len();
    case ($urandom_range(9))
      0:       return 0;
      1:       return {$urandom, $urandom};
      2:       return TOP;
      default: return $urandom_range(1, 120);
    endcase
  endfunction

  // Directed rows: extremes, full table, zero length, overflow, no gaps.
  row_t plan[$];

  task automatic add_row(func_t f, logic [63:0] o, logic [63:0] l,
                         logic [63:0] d, bit c, result_t r);
    row_t w;
    w.f = f; w.off = o; w.len = l; w.dev = d; w.chk = c; w.res = r;
    plan = {plan, w};
  endtask

  initial begin
    result_t none;
    row_t w;
    int guard;
    none = '0;
    fails = 0;
    mismatches = 0;
    idle_mode = 0;
    hold_cycles = 0;
    span_cnt = 0;
    span_bytes = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    func = FUNC_ADD;
    region_offset = 0;
    region_length = 0;
    device_size = 0;
    // Empty table after reset.
    add_row(FUNC_GAPS, 0, 0, 0, 1, '{0, 0, 0, 0, 1, 0, 0, 0});
    add_row(FUNC_GAPS, 0, 0, TOP, 1, '{0, 1, 0, TOP, 1, 0, 0, 0});
    add_row(FUNC_QUERY, 5, 10, 0, 1, '{0, 0, 0, 0, 1, 0, 0, 0});
    add_row(FUNC_ADD, 7, 0, 0, 1, '{0, 0, 0, 0, 1, 0, 0, 0});
    add_row(FUNC_NONE, TOP, TOP, TOP, 1, '{0, 0, 0, 0, 1, 0, 0, 0});
    add_row(FUNC_ADD, 100, 50, 0, 1, '{0, 0, 0, 0, 1, 50, 1, 0});
    add_row(FUNC_ADD, 150, 10, 0, 0, none);   // touches end to end
    add_row(FUNC_ADD, 90, 10, 0, 0, none);
    add_row(FUNC_QUERY, 160, 5, 0, 0, none);
    add_row(FUNC_QUERY, 159, 1, 0, 0, none);
    add_row(FUNC_QUERY, 0, 0, 0, 0, none);
    add_row(FUNC_ADD, TOP, 5, 0, 0, none);    // empty entry at the top
    add_row(FUNC_ADD, TOP - 10, TOP, 0, 0, none);
    add_row(FUNC_ADD, 0, 1, 0, 0, none);
    add_row(FUNC_GAPS, 0, 0, 120, 0, none);
    add_row(FUNC_GAPS, 0, 0, TOP, 0, none);
    add_row(FUNC_QUERY, TOP - 1, TOP, 0, 0, none);
    // Fill the table, then one more disjoint add overflows it.
    for (int k = 0; k < NRANGE; k++) add_row(FUNC_ADD, 1000 + 4 * k, 2, 0, 0, none);
    add_row(FUNC_ADD, 500, 3, 0, 0, none);
    add_row(FUNC_GAPS, 0, 0, 2000, 0, none);
    add_row(FUNC_ADD, 0, TOP, 0, 0, none);    // swallow everything
    add_row(FUNC_GAPS, 0, 0, TOP, 0, none);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (plan[k]) begin
      w = plan[k];
      send_item(w.f, w.off, w.len, w.dev);
      // Typed-in answer must agree with the predictor.
      if (w.chk && expected_results.size() != 0 &&
          expected_results[expected_results.size()-1] !== w.res) begin
        fails++;
        $display("directed row %0d: table entry %p disagrees", k, w.res);
      end
    end
    // Long hold-off while items keep coming, so the input backs up.
    hold_cycles = 400;
    for (int ph = 0; ph < 4; ph++) begin
      idle_mode = ph;
      // Mixed random items; the table carries over from phase to phase.
      repeat (77) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: send_item(FUNC_ADD, rand_addr(), rand_len(), 0);
          5, 6:          send_item(FUNC_QUERY, rand_addr(), rand_len(), 0);
          7:             send_item(FUNC_GAPS, 0, 0, rand_addr());
          8:             send_item(FUNC_GAPS, 0, 0, {$urandom, $urandom});
          default:       send_item(func_t'($urandom_range(3)), {$urandom, $urandom},
                                   {$urandom, $urandom}, {$urandom, $urandom});
        endcase
      end
    end
    in_valid <= 1'b0;
    guard = 0;
    while (expected_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
    if (fails == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
`default_nettype wire
